// File: hdl/sphvf_pkg.sv
// Shared widths, latencies and types for the pair viscous force pipeline.
`timescale 1ns / 1ps
`default_nettype none

package sphvf_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_KFACT = 2'd1;
	localparam logic [31:0] KFACT_RESET = 32'h0005_0000;

	// harmonic mean unit: product stage, one stage per quotient bit, rounding stage
	localparam int HM_STEPS = 32;
	localparam int HM_LAT   = HM_STEPS + 2;

	// final divider: six lanes, 40 quotient bits plus an overflow check stage
	localparam int LANES    = 6;
	localparam int N_W      = 148;
	localparam int D_W      = 96;
	localparam int Q_W      = 40;
	localparam int QD_STEPS = Q_W;
	localparam int QD_LAT   = QD_STEPS + 1;

	// stages before the divider, divider, output register
	localparam int PIPE_DEPTH = HM_LAT + 10 + QD_LAT + 1;

	localparam logic [Q_W-1:0] SAT_POS = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] SAT_NEG = {1'b1, {(Q_W-1){1'b0}}};

	typedef logic [N_W-1:0] num_t;
	typedef logic [D_W-1:0] den_t;
	typedef logic [Q_W-1:0] quo_t;

	typedef struct packed {
		logic [LANES-1:0] neg;
		logic             kill;
		logic             negdiff;
	} qside_t;

endpackage

`default_nettype wire

// File: hdl/sphvf_hmean.sv
// Pipelined harmonic mean floor(2ab/(a+b)), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module sphvf_hmean import sphvf_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] h
);

	logic [63:0] prod;
	logic [32:0] sum_s  [0:HM_STEPS];
	logic [32:0] rem_s  [0:HM_STEPS];
	logic [31:0] low_s  [0:HM_STEPS];
	logic [31:0] quo_s  [0:HM_STEPS];
	logic        zero_s [0:HM_STEPS];
	logic [33:0] trial_c [HM_STEPS];
	logic        ge_c    [HM_STEPS];
	logic [32:0] rem_c   [HM_STEPS];
	logic        rnd;
	logic [31:0] mean_s34;

	assign prod = 64'(a) * 64'(b);

	always_comb begin
		for (int j = 0; j < HM_STEPS; j++) begin
			trial_c[j] = {rem_s[j], low_s[j][31]};
			ge_c[j]    = trial_c[j] >= {1'b0, sum_s[j]};
			rem_c[j]   = ge_c[j] ? 33'(trial_c[j] - {1'b0, sum_s[j]}) : trial_c[j][32:0];
		end
	end

	// round up when twice the remainder reaches the divisor
	assign rnd = {rem_s[HM_STEPS], 1'b0} >= {1'b0, sum_s[HM_STEPS]};

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s[0]  <= {1'b0, a} + {1'b0, b};
			rem_s[0]  <= {1'b0, prod[63:32]};
			low_s[0]  <= prod[31:0];
			quo_s[0]  <= '0;
			zero_s[0] <= (a == 32'h0) || (b == 32'h0);
			for (int j = 0; j < HM_STEPS; j++) begin
				sum_s[j+1]  <= sum_s[j];
				rem_s[j+1]  <= rem_c[j];
				low_s[j+1]  <= {low_s[j][30:0], 1'b0};
				quo_s[j+1]  <= {quo_s[j][30:0], ge_c[j]};
				zero_s[j+1] <= zero_s[j];
			end
			mean_s34 <= zero_s[HM_STEPS] ? 32'h0 :
				{quo_s[HM_STEPS][30:0], 1'b0} + 32'(rnd);
		end
	end

	assign h = mean_s34;

endmodule

`default_nettype wire

// File: hdl/sphvf_qdiv.sv
// Six-lane pipelined restoring divider with a shared divisor and overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module sphvf_qdiv import sphvf_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  num_t [LANES-1:0]     num,
	input  den_t                 den,
	input  qside_t               side_in,
	output quo_t [LANES-1:0]     quo,
	output logic [LANES-1:0]     ovf,
	output qside_t               side_out
);

	den_t             den_s  [0:QD_STEPS];
	qside_t           side_s [0:QD_STEPS];
	logic [LANES-1:0] ovf_s  [0:QD_STEPS];
	den_t             rem_s  [0:QD_STEPS][LANES];
	quo_t             low_s  [0:QD_STEPS][LANES];
	quo_t             quo_s  [0:QD_STEPS][LANES];
	logic [D_W:0]     trial_c [QD_STEPS][LANES];
	logic             ge_c    [QD_STEPS][LANES];
	den_t             rem_c   [QD_STEPS][LANES];

	always_comb begin
		for (int j = 0; j < QD_STEPS; j++) begin
			for (int l = 0; l < LANES; l++) begin
				trial_c[j][l] = {rem_s[j][l], low_s[j][l][Q_W-1]};
				ge_c[j][l]    = trial_c[j][l] >= {1'b0, den_s[j]};
				rem_c[j][l]   = ge_c[j][l] ? D_W'(trial_c[j][l] - {1'b0, den_s[j]}) :
					trial_c[j][l][D_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= den;
			side_s[0] <= side_in;
			for (int l = 0; l < LANES; l++) begin
				// quotient of 2^40 or more saturates anyway
				ovf_s[0][l]  <= num[l][N_W-1:Q_W] >= (N_W-Q_W)'(den);
				rem_s[0][l]  <= num[l][Q_W+D_W-1:Q_W];
				low_s[0][l]  <= num[l][Q_W-1:0];
				quo_s[0][l]  <= '0;
			end
			for (int j = 0; j < QD_STEPS; j++) begin
				den_s[j+1]  <= den_s[j];
				side_s[j+1] <= side_s[j];
				ovf_s[j+1]  <= ovf_s[j];
				for (int l = 0; l < LANES; l++) begin
					rem_s[j+1][l] <= rem_c[j][l];
					low_s[j+1][l] <= {low_s[j][l][Q_W-2:0], 1'b0};
					quo_s[j+1][l] <= {quo_s[j][l][Q_W-2:0], ge_c[j][l]};
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quo[l] = quo_s[QD_STEPS][l];
		end
	end

	assign ovf      = ovf_s[QD_STEPS];
	assign side_out = side_s[QD_STEPS];

endmodule

`default_nettype wire

// File: hdl/sph_pair_viscous_force_unit.sv
// Top level: viscous acceleration increments for one particle pair per cycle unless a valid output is stalled.
//
//  channel   handshake               payload
//  -------   ---------------------   --------------------------------------------
//  in        in_valid / in_stall     densities, velocities, direction, distance,
//                                    coefficients, shear and bulk viscosities
//  out       out_valid / out_stall   six accelerations, negative_diffusion
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pair enters per cycle unless a valid output is stalled.
// The pipeline depth comes from the harmonic mean dividers (one bit a stage) and the
// six-lane final divider (40 quotient bits, one a stage).
// Reset clears the valid chain and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module sph_pair_viscous_force_unit import sphvf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          density_first,
	input  logic [31:0]          density_second,
	input  logic [62:0]          velocity_first,
	input  logic [62:0]          velocity_second,
	input  logic [62:0]          direction,
	input  logic [31:0]          distance,
	input  logic signed [31:0]   coef_first,
	input  logic signed [31:0]   coef_second,
	input  logic [31:0]          shear_visc_first,
	input  logic [31:0]          shear_visc_second,
	input  logic [31:0]          bulk_visc_first,
	input  logic [31:0]          bulk_visc_second,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [39:0]   accel_first_x,
	output logic signed [39:0]   accel_first_y,
	output logic signed [39:0]   accel_first_z,
	output logic signed [39:0]   accel_second_x,
	output logic signed [39:0]   accel_second_y,
	output logic signed [39:0]   accel_second_z,
	output logic                 negative_diffusion,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int SIDE_DLY = HM_LAT - 5;
	localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

	typedef struct packed {
		logic [2:0][20:0] dvmag;
		logic [2:0]       dvneg;
		logic [2:0]       t2neg;
		logic [2:0][63:0] prd;
		logic [31:0]      cmag1;
		logic [31:0]      cmag2;
		logic             c1neg;
		logic             c2pos;
		den_t             den;
		logic             dzero;
	} side_t;

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  mode_q;
	logic [31:0]           kf_q;

	assign en        = ~(out_valid & out_stall);
	assign in_stall  = ~en;
	assign out_valid = vld_q[PIPE_DEPTH-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			kf_q   <= KFACT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IDX_MODE:  mode_q <= cfg_data[0];
				CFG_IDX_KFACT: kf_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- geometry side path, stages 1 to 5 ----------------
	logic signed [21:0] dv_s1  [3];
	logic signed [20:0] dir_s1 [3];
	logic [63:0]        dd_s1;
	logic [31:0]        dist_s1;
	logic signed [31:0] c1_s1, c2_s1;

	logic [63:0]        dlo_s2, dhi_s2;
	logic signed [42:0] prod_s2 [3];
	logic signed [21:0] dv_s2   [3];
	logic signed [20:0] dir_s2  [3];
	logic [31:0]        dist_s2;
	logic signed [31:0] c1_s2, c2_s2;

	den_t               den_s3;
	logic signed [44:0] dot_s3;
	logic [20:0]        dvmag_s3  [3];
	logic [2:0]         dvneg_s3;
	logic [20:0]        dirmag_s3 [3];
	logic [2:0]         dirneg_s3;
	logic [31:0]        cmag1_s3, cmag2_s3;
	logic               c1neg_s3, c2pos_s3;

	den_t               den_s4;
	logic               dzero_s4;
	logic [42:0]        dotmag_s4;
	logic               dotneg_s4;
	logic [20:0]        dvmag_s4  [3];
	logic [2:0]         dvneg_s4;
	logic [20:0]        dirmag_s4 [3];
	logic [2:0]         dirneg_s4;
	logic [31:0]        cmag1_s4, cmag2_s4;
	logic               c1neg_s4, c2pos_s4;

	side_t              side_s5;
	side_t              side_dly [SIDE_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dv_s1[k]  <= 22'(signed'(velocity_first[21*k +: 21])) -
					22'(signed'(velocity_second[21*k +: 21]));
				dir_s1[k] <= direction[21*k +: 21];
			end
			dd_s1   <= 64'(density_first) * 64'(density_second);
			dist_s1 <= distance;
			c1_s1   <= coef_first;
			c2_s1   <= coef_second;

			dlo_s2 <= 64'(dd_s1[31:0]) * 64'(dist_s1);
			dhi_s2 <= 64'(dd_s1[63:32]) * 64'(dist_s1);
			for (int k = 0; k < 3; k++) begin
				prod_s2[k] <= 43'(dv_s1[k]) * 43'(dir_s1[k]);
				dv_s2[k]   <= dv_s1[k];
				dir_s2[k]  <= dir_s1[k];
			end
			dist_s2 <= dist_s1;
			c1_s2   <= c1_s1;
			c2_s2   <= c2_s1;

			den_s3 <= mode_q ? D_W'({dist_s2, 32'h0}) : D_W'(dlo_s2) + {dhi_s2, 32'h0};
			dot_s3 <= 45'(prod_s2[0]) + 45'(prod_s2[1]) + 45'(prod_s2[2]);
			for (int k = 0; k < 3; k++) begin
				dvmag_s3[k]  <= dv_s2[k][21] ? 21'(-dv_s2[k]) : 21'(dv_s2[k]);
				dvneg_s3[k]  <= dv_s2[k][21];
				dirmag_s3[k] <= dir_s2[k][20] ? 21'(-dir_s2[k]) : 21'(dir_s2[k]);
				dirneg_s3[k] <= dir_s2[k][20];
			end
			cmag1_s3 <= c1_s2[31] ? 32'(-c1_s2) : 32'(c1_s2);
			cmag2_s3 <= c2_s2[31] ? 32'(-c2_s2) : 32'(c2_s2);
			c1neg_s3 <= c1_s2[31];
			c2pos_s3 <= !c2_s2[31] && (c2_s2 != 32'sd0);

			den_s4    <= den_s3;
			dzero_s4  <= den_s3 == '0;
			dotmag_s4 <= dot_s3[44] ? 43'(-dot_s3) : 43'(dot_s3);
			dotneg_s4 <= dot_s3[44];
			dvmag_s4  <= dvmag_s3;
			dvneg_s4  <= dvneg_s3;
			dirmag_s4 <= dirmag_s3;
			dirneg_s4 <= dirneg_s3;
			cmag1_s4  <= cmag1_s3;
			cmag2_s4  <= cmag2_s3;
			c1neg_s4  <= c1neg_s3;
			c2pos_s4  <= c2pos_s3;

			for (int k = 0; k < 3; k++) begin
				side_s5.dvmag[k] <= dvmag_s4[k];
				side_s5.prd[k]   <= 64'(dotmag_s4) * 64'(dirmag_s4[k]);
				side_s5.t2neg[k] <= dotneg_s4 ^ dirneg_s4[k];
			end
			side_s5.dvneg <= dvneg_s4;
			side_s5.cmag1 <= cmag1_s4;
			side_s5.cmag2 <= cmag2_s4;
			side_s5.c1neg <= c1neg_s4;
			side_s5.c2pos <= c2pos_s4;
			side_s5.den   <= den_s4;
			side_s5.dzero <= dzero_s4;

			// hold the geometry until the harmonic means are ready
			side_dly[0] <= side_s5;
			for (int i = 1; i < SIDE_DLY; i++) begin
				side_dly[i] <= side_dly[i-1];
			end
		end
	end

	// ---------------- harmonic means, stages 1 to 34 ----------------
	logic [31:0] hs_s34, hb_s34;

	sphvf_hmean u_hm_shear (
		.clk (clk),
		.en  (en),
		.a   (shear_visc_first),
		.b   (shear_visc_second),
		.h   (hs_s34)
	);

	sphvf_hmean u_hm_bulk (
		.clk (clk),
		.en  (en),
		.a   (bulk_visc_first),
		.b   (bulk_visc_second),
		.h   (hb_s34)
	);

	// ---------------- coefficients and forces, stages 35 to 44 ----------------
	// side_sm[i] is the geometry at stage 35 + i
	side_t              side_sm [9];
	logic               nd_sm   [8];
	logic [63:0]        s3prod;
	logic [34:0]        diff_c;
	logic [30:0]        s_s35;
	logic [31:0]        k_s35, v_s35;
	logic [32:0]        sum_s36;
	logic [32:0]        coef_s36;
	logic [48:0]        chi_s37;
	logic [47:0]        clo_s37;
	logic [53:0]        t1r_s37 [3];
	logic [49:0]        conv_s38;
	logic [53:0]        t1r_s38 [3];
	logic [56:0]        pp_s39  [3][4];
	logic [53:0]        t1r_s39 [3];
	logic [113:0]       t2_s40  [3];
	logic [53:0]        t1r_s40 [3];
	logic signed [114:0] bt1_c  [3];
	logic signed [114:0] bt2_c  [3];
	logic signed [114:0] b_s41  [3];
	logic signed [114:0] bneg_c [3];
	logic [113:0]       bmag_s42 [3];
	logic [2:0]         bneg_s42;
	logic [115:0]       bpad_c  [3];
	logic [60:0]        npp_s43 [3][2][4];
	logic [2:0]         bneg_s43;
	num_t [LANES-1:0]   num_s44;
	num_t [LANES-1:0]   num_c;
	den_t               den_s44;
	qside_t             qs_s44;

	assign s3prod = 64'(hs_s34) * 64'(DIV3_RECIP);
	assign diff_c = (35'(side_sm[0].cmag1) & '0) + (35'(s_s35) << 2) + 35'(s_s35) - 35'(k_s35);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			bt1_c[k]  = side_sm[5].dvneg[k] ? -115'({t1r_s40[k], 20'h0}) :
				115'({t1r_s40[k], 20'h0});
			bt2_c[k]  = side_sm[5].t2neg[k] ? -115'(t2_s40[k]) : 115'(t2_s40[k]);
			bneg_c[k] = -b_s41[k];
			bpad_c[k] = 116'(bmag_s42[k]);
		end
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < 2; c++) begin
				num_c[3*c + k] = '0;
				for (int i = 0; i < 4; i++) begin
					num_c[3*c + k] = num_c[3*c + k] + (N_W'(npp_s43[k][c][i]) << (29*i));
				end
				num_c[3*c + k] = num_c[3*c + k] << 2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sm[0] <= side_dly[SIDE_DLY-1];
			for (int i = 1; i < 9; i++) begin
				side_sm[i] <= side_sm[i-1];
			end

			// shear mean divided by three through a reciprocal
			s_s35 <= s3prod[63:33];
			k_s35 <= hb_s34;
			v_s35 <= hs_s34;

			sum_s36  <= 33'(s_s35) + 33'(k_s35);
			coef_s36 <= mode_q ? 33'(v_s35) : diff_c[32:0];
			nd_sm[0] <= !mode_q && diff_c[34];
			for (int i = 1; i < 8; i++) begin
				nd_sm[i] <= nd_sm[i-1];
			end

			chi_s37 <= 49'(kf_q) * 49'(sum_s36[32:16]);
			clo_s37 <= 48'(kf_q) * 48'(sum_s36[15:0]);
			for (int k = 0; k < 3; k++) begin
				t1r_s37[k] <= 54'(coef_s36) * 54'(side_sm[1].dvmag[k]);
			end

			conv_s38 <= mode_q ? '0 : 50'(chi_s37) + 50'(clo_s37[47:16]);
			t1r_s38  <= t1r_s37;

			for (int k = 0; k < 3; k++) begin
				pp_s39[k][0] <= 57'(conv_s38[24:0]) * 57'(side_sm[3].prd[k][31:0]);
				pp_s39[k][1] <= 57'(conv_s38[24:0]) * 57'(side_sm[3].prd[k][63:32]);
				pp_s39[k][2] <= 57'(conv_s38[49:25]) * 57'(side_sm[3].prd[k][31:0]);
				pp_s39[k][3] <= 57'(conv_s38[49:25]) * 57'(side_sm[3].prd[k][63:32]);
			end
			t1r_s39 <= t1r_s38;

			for (int k = 0; k < 3; k++) begin
				t2_s40[k] <= 114'(pp_s39[k][0]) + (114'(pp_s39[k][1]) << 32) +
					(114'(pp_s39[k][2]) << 25) + (114'(pp_s39[k][3]) << 57);
			end
			t1r_s40 <= t1r_s39;

			for (int k = 0; k < 3; k++) begin
				b_s41[k] <= bt1_c[k] + bt2_c[k];
			end

			for (int k = 0; k < 3; k++) begin
				bneg_s42[k] <= b_s41[k][114];
				bmag_s42[k] <= b_s41[k][114] ? bneg_c[k][113:0] : b_s41[k][113:0];
			end

			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 4; i++) begin
					npp_s43[k][0][i] <= 61'(side_sm[7].cmag1) * 61'(bpad_c[k][29*i +: 29]);
					npp_s43[k][1][i] <= 61'(side_sm[7].cmag2) * 61'(bpad_c[k][29*i +: 29]);
				end
			end
			bneg_s43 <= bneg_s42;

			num_s44 <= num_c;
			den_s44 <= side_sm[8].den;
			for (int k = 0; k < 3; k++) begin
				qs_s44.neg[k]     <= bneg_s43[k] ^ side_sm[8].c1neg;
				qs_s44.neg[3 + k] <= bneg_s43[k] ^ side_sm[8].c2pos;
			end
			qs_s44.kill    <= nd_sm[7] || side_sm[8].dzero;
			qs_s44.negdiff <= nd_sm[7];
		end
	end

	// ---------------- final division, stages 45 to 85 ----------------
	quo_t [LANES-1:0] quo_s85;
	logic [LANES-1:0] ovf_s85;
	qside_t           qs_s85;

	sphvf_qdiv u_qdiv (
		.clk      (clk),
		.en       (en),
		.num      (num_s44),
		.den      (den_s44),
		.side_in  (qs_s44),
		.quo      (quo_s85),
		.ovf      (ovf_s85),
		.side_out (qs_s85)
	);

	// ---------------- sign, saturation and output register ----------------
	logic [Q_W-1:0] acc_c   [LANES];
	logic [Q_W-1:0] acc_s86 [LANES];
	logic           nd_s86;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (qs_s85.kill) begin
				acc_c[l] = '0;
			end else if (qs_s85.neg[l]) begin
				acc_c[l] = (ovf_s85[l] || (quo_s85[l] > SAT_NEG)) ? SAT_NEG : -quo_s85[l];
			end else begin
				acc_c[l] = (ovf_s85[l] || quo_s85[l][Q_W-1]) ? SAT_POS : quo_s85[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s86 <= acc_c;
			nd_s86  <= qs_s85.negdiff;
		end
	end

	assign accel_first_x      = acc_s86[0];
	assign accel_first_y      = acc_s86[1];
	assign accel_first_z      = acc_s86[2];
	assign accel_second_x     = acc_s86[3];
	assign accel_second_y     = acc_s86[4];
	assign accel_second_z     = acc_s86[5];
	assign negative_diffusion = nd_s86;

endmodule

`default_nettype wire

// File: tb/sphvf_checker.sv
// Checker for the pair viscous force unit: predicts each result and compares it.
`timescale 1ns / 1ps

module sphvf_checker import sphvf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [31:0]          density_first,
	input  logic [31:0]          density_second,
	input  logic [62:0]          velocity_first,
	input  logic [62:0]          velocity_second,
	input  logic [62:0]          direction,
	input  logic [31:0]          distance,
	input  logic [31:0]          coef_first,
	input  logic [31:0]          coef_second,
	input  logic [31:0]          shear_visc_first,
	input  logic [31:0]          shear_visc_second,
	input  logic [31:0]          bulk_visc_first,
	input  logic [31:0]          bulk_visc_second,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [39:0]          accel_first_x,
	input  logic [39:0]          accel_first_y,
	input  logic [39:0]          accel_first_z,
	input  logic [39:0]          accel_second_x,
	input  logic [39:0]          accel_second_y,
	input  logic [39:0]          accel_second_z,
	input  logic                 negative_diffusion,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   fail_count,
	output int                   pending
);

	typedef logic signed [199:0] wide_t;

	// acc order: first x, y, z, then second x, y, z
	typedef struct packed {
		logic [5:0][39:0] acc;
		logic             negdiff;
	} accel_t;

	logic        mode_visc_dist;
	logic [31:0] kfact;
	accel_t      expected_accel_q[$];

	function automatic logic [32:0] harmonic_mean(input logic [31:0] a, input logic [31:0] b);
		logic [65:0] num;
		logic [65:0] sum;
		if (a == 0 || b == 0)
			return '0;
		num = 66'(a) * 66'(b) * 66'd2;
		sum = 66'(a) + 66'(b);
		return 33'(num / sum);
	endfunction

	function automatic logic [39:0] saturate(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< 39) - 1;
		lo = -(wide_t'(1) <<< 39);
		if (v > hi)
			return SAT_POS;
		if (v < lo)
			return SAT_NEG;
		return v[39:0];
	endfunction

	function automatic accel_t pair_force_predict(input logic visc_dist, input logic [31:0] kf,
			input logic [31:0] d1, input logic [31:0] d2, input logic [62:0] vf,
			input logic [62:0] vs, input logic [62:0] dir, input logic [31:0] sep,
			input logic [31:0] c1, input logic [31:0] c2, input logic [31:0] sv1,
			input logic [31:0] sv2, input logic [31:0] bv1, input logic [31:0] bv2);
		accel_t r;
		logic [32:0] hs;
		logic [32:0] hb;
		wide_t shear, bulk, conv, diff, dot, den, cf, cs, q, t1, t2, t3, va, vb;
		wide_t dv[3];
		wide_t dr[3];
		wide_t bk[3];
		r = '0;
		for (int k = 0; k < 3; k++) begin
			va = $signed(vf[21*k +: 21]);
			vb = $signed(vs[21*k +: 21]);
			dv[k] = va - vb;
			dr[k] = $signed(dir[21*k +: 21]);
		end
		cf = $signed(c1);
		cs = $signed(c2);
		t1 = d1;
		t2 = d2;
		t3 = sep;
		if (!visc_dist) begin
			hs = harmonic_mean(sv1, sv2);
			hb = harmonic_mean(bv1, bv2);
			shear = hs / 3;
			bulk = hb;
			q = kf;
			conv = ((shear + bulk) * q) >>> 16;
			diff = shear * 5 - bulk;
			if (diff < 0) begin
				r.negdiff = 1'b1;
				return r;
			end
			den = t1 * t2 * t3;
			dot = 0;
			for (int k = 0; k < 3; k++)
				dot = dot + dv[k] * dr[k];
			for (int k = 0; k < 3; k++)
				bk[k] = ((diff * dv[k]) <<< 20) + conv * dot * dr[k];
		end else begin
			hs = harmonic_mean(sv1, sv2);
			if (hs == 0)
				return r;
			shear = hs;
			den = t3 <<< 32;
			for (int k = 0; k < 3; k++)
				bk[k] = (shear * dv[k]) <<< 20;
		end
		if (den == 0)
			return r;
		for (int k = 0; k < 3; k++) begin
			r.acc[k] = saturate((cf * bk[k] * 4) / den);
			r.acc[3+k] = saturate(-((cs * bk[k] * 4) / den));
		end
		return r;
	endfunction

	assign pending = expected_accel_q.size();

	always @(posedge clk or negedge arst_n) begin
		accel_t got;
		accel_t want;
		if (!arst_n) begin
			mode_visc_dist <= 1'b0;
			kfact <= KFACT_RESET;
			fail_count <= 0;
			expected_accel_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_IDX_MODE)
					mode_visc_dist <= cfg_data[0];
				else if (cfg_index == CFG_IDX_KFACT)
					kfact <= cfg_data;
			end
			if (in_valid && !in_stall)
				expected_accel_q.push_back(pair_force_predict(mode_visc_dist, kfact,
					density_first, density_second, velocity_first, velocity_second,
					direction, distance, coef_first, coef_second, shear_visc_first,
					shear_visc_second, bulk_visc_first, bulk_visc_second));
			if (out_valid && !out_stall) begin
				got.acc = {accel_second_z, accel_second_y, accel_second_x,
					accel_first_z, accel_first_y, accel_first_x};
				got.negdiff = negative_diffusion;
				if (expected_accel_q.size() == 0) begin
					if (fail_count < 10)
						$display("%t unexpected result %h", $realtime, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_accel_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10) begin
							$display("%t mismatch", $realtime);
							for (int k = 0; k < 6; k++)
								$display("  accel[%0d] exp %h got %h", k, want.acc[k],
									got.acc[k]);
							$display("  negdiff exp %b got %b", want.negdiff, got.negdiff);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// File: tb/tb_sph_pair_viscous_force_unit.sv
// Testbench top: stimulus, receiver stalls and verdict for the pair viscous force unit.
`timescale 1ns / 1ps

module tb_sph_pair_viscous_force_unit;
	import sphvf_pkg::*;

	localparam logic                 FORM_HARMONIC_BULK = 1'b0;
	localparam logic                 FORM_VISC_DIST     = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_A   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_B   = 2'd3;
	localparam logic [20:0]          COMP_MIN           = 21'h100000;
	localparam logic [20:0]          COMP_MAX           = 21'h0FFFFF;
	localparam logic [31:0]          ONE_Q16            = 32'h0001_0000;

	typedef struct packed {
		logic [31:0] d1;
		logic [31:0] d2;
		logic [62:0] vf;
		logic [62:0] vs;
		logic [62:0] dir;
		logic [31:0] sep;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] sv1;
		logic [31:0] sv2;
		logic [31:0] bv1;
		logic [31:0] bv2;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	pair_t cur = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [39:0] afx, afy, afz, asx, asy, asz;
	logic negdiff;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int fail_count;
	int pending;
	int hold_cycles = 0;
	int stall_style = 0;
	int burst_left = 0;

	always #4 clk = ~clk;

	sph_pair_viscous_force_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.density_first(cur.d1), .density_second(cur.d2), .velocity_first(cur.vf),
		.velocity_second(cur.vs), .direction(cur.dir), .distance(cur.sep),
		.coef_first(cur.c1), .coef_second(cur.c2), .shear_visc_first(cur.sv1),
		.shear_visc_second(cur.sv2), .bulk_visc_first(cur.bv1),
		.bulk_visc_second(cur.bv2), .out_valid(out_valid), .out_stall(out_stall),
		.accel_first_x(afx), .accel_first_y(afy), .accel_first_z(afz),
		.accel_second_x(asx), .accel_second_y(asy), .accel_second_z(asz),
		.negative_diffusion(negdiff), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sphvf_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.density_first(cur.d1), .density_second(cur.d2), .velocity_first(cur.vf),
		.velocity_second(cur.vs), .direction(cur.dir), .distance(cur.sep),
		.coef_first(cur.c1), .coef_second(cur.c2), .shear_visc_first(cur.sv1),
		.shear_visc_second(cur.sv2), .bulk_visc_first(cur.bv1),
		.bulk_visc_second(cur.bv2), .out_valid(out_valid), .out_stall(out_stall),
		.accel_first_x(afx), .accel_first_y(afy), .accel_first_z(afz),
		.accel_second_x(asx), .accel_second_y(asy), .accel_second_z(asz),
		.negative_diffusion(negdiff), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
		.pending(pending)
	);

	function automatic logic [31:0] rand_scalar(input bit allow_zero);
		case ($urandom_range(0, 5))
			0: rand_scalar = $urandom;
			1: rand_scalar = ONE_Q16 + $urandom_range(0, 32'h3_0000);
			2: rand_scalar = $urandom_range(1, 32'h2000);
			3: rand_scalar = 32'hFFFF_FFFF - $urandom_range(0, 255);
			4: rand_scalar = $urandom_range(32'h4000, 32'h10_0000);
			default: rand_scalar = allow_zero ? 32'h0 : ONE_Q16;
		endcase
	endfunction

	function automatic logic [62:0] rand_vec();
		logic [62:0] v;
		v = {$urandom, $urandom};
		for (int k = 0; k < 3; k++)
			if ($urandom_range(0, 2) == 0)
				v[21*k +: 21] = 21'($signed($urandom_range(0, 2048)) - 1024);
		return v;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		p.d1 = rand_scalar(1'b0);
		p.d2 = rand_scalar(1'b0);
		p.vf = rand_vec();
		p.vs = rand_vec();
		p.dir = rand_vec();
		p.sep = rand_scalar(1'b0);
		p.c1 = ($urandom_range(0, 2) == 0) ? $urandom :
			32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
		p.c2 = ($urandom_range(0, 2) == 0) ? $urandom :
			32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
		p.sv1 = rand_scalar(1'b1);
		p.sv2 = rand_scalar(1'b1);
		p.bv1 = rand_scalar(1'b1);
		p.bv2 = rand_scalar(1'b1);
		// keep bulk small in most pairs so the diffusion term stays positive
		if ($urandom_range(0, 2) != 0) begin
			p.bv1 = p.bv1 >> $urandom_range(4, 20);
			p.bv2 = p.bv2 >> $urandom_range(4, 20);
		end
		return p;
	endfunction

	// offer one item, hold it until taken, then maybe open a gap
	task automatic send_pair(input pair_t p);
		cur <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			if ($urandom_range(0, 1)) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_directed();
		pair_t p;
		pair_t base;
		base = '0;
		base.d1 = ONE_Q16;
		base.d2 = ONE_Q16;
		base.sep = ONE_Q16;
		base.vf = {21'd300, 21'd200, 21'd100};
		base.vs = {21'd0, 21'd0, 21'd0};
		base.dir = {21'd0, 21'd0, 21'h40000};
		base.c1 = ONE_Q16;
		base.c2 = ONE_Q16;
		base.sv1 = ONE_Q16;
		base.sv2 = 32'h0003_0000;
		base.bv1 = 32'h0000_4000;
		base.bv2 = 32'h0000_8000;
		send_pair(base);
		p = base; p.bv1 = 32'hFFFF_FFFF; p.bv2 = 32'hFFFF_FFFF;  // diffusion below zero
		send_pair(p);
		p = base; p.sv1 = 32'h0;  // zero shear viscosity
		send_pair(p);
		p = base; p.sv1 = 32'h0; p.sv2 = 32'h0; p.bv1 = 32'h0; p.bv2 = 32'h0;
		send_pair(p);
		p = base; p.d1 = 32'h0;  // zero density
		send_pair(p);
		p = base; p.sep = 32'h0;  // zero distance
		send_pair(p);
		p = base; p.d1 = 32'h1; p.d2 = 32'h1; p.sep = 32'h1;  // tiny divisor, saturate
		send_pair(p);
		p = base; p.d1 = 32'hFFFF_FFFF; p.d2 = 32'hFFFF_FFFF; p.sep = 32'hFFFF_FFFF;
		send_pair(p);
		p = base; p.vf = {COMP_MAX, COMP_MAX, COMP_MAX}; p.vs = {COMP_MIN, COMP_MIN, COMP_MIN};
		p.dir = {COMP_MIN, COMP_MAX, COMP_MIN}; p.sep = 32'h1;
		send_pair(p);
		p = base; p.vf = {COMP_MIN, COMP_MIN, COMP_MIN}; p.vs = {COMP_MAX, COMP_MAX, COMP_MAX};
		p.c1 = 32'h8000_0000; p.c2 = 32'h7FFF_FFFF;
		send_pair(p);
		p = base; p.c1 = 32'h0; p.c2 = 32'hFFFF_FFFF;
		send_pair(p);
		p = base; p.sv1 = 32'hFFFF_FFFF; p.sv2 = 32'hFFFF_FFFF; p.bv1 = 32'h1; p.bv2 = 32'h1;
		send_pair(p);
		p = base; p.vf = p.vs;  // no relative velocity
		send_pair(p);
		p = '1; p.d1 = 32'hFFFF_FFFF;
		send_pair(p);
	endtask

	task automatic run_random(input int count, input bit long_hold, input bit mid_pause);
		for (int i = 0; i < count; i++) begin
			if (long_hold && i == count / 4)
				hold_cycles = 400;
			if (mid_pause && i == count / 2)
				wait_drained();
			send_pair(random_pair());
		end
	endtask

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int cyc;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles - 1) @(posedge clk);
				hold_cycles = 0;
			end else begin
				case (stall_style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ((cyc % 11) < 4);
				endcase
				if ($urandom_range(0, 199) == 0)
					stall_style = $urandom_range(0, 2);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("** sph_pair_viscous_force_unit: FAILED **");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		write_reg(CFG_IDX_MODE, {31'd0, FORM_VISC_DIST});
		run_directed();
		run_random(150, 1'b0, 1'b0);
		wait_drained();
		write_reg(CFG_IDX_MODE, {31'd0, FORM_HARMONIC_BULK});
		write_reg(CFG_IDX_KFACT, 32'h0);
		run_random(280, 1'b1, 1'b0);
		wait_drained();
		write_reg(CFG_IDX_KFACT, 32'hFFFF_FFFF);
		run_random(280, 1'b0, 1'b1);
		wait_drained();
		write_reg(CFG_IDX_KFACT, $urandom);
		write_reg(CFG_IDX_UNUSED_A, 32'hFFFF_FFFF);
		write_reg(CFG_IDX_UNUSED_B, 32'h0);
		run_random(300, 1'b0, 1'b0);
		wait_drained();
		write_reg(CFG_IDX_MODE, 32'hFFFF_FFFF);
		run_random(300, 1'b1, 1'b0);
		wait_drained();
		write_reg(CFG_IDX_MODE, 32'hFFFF_FFFE);
		write_reg(CFG_IDX_KFACT, KFACT_RESET);
		run_random(400, 1'b0, 1'b0);
		wait_drained();
		if (fail_count == 0 && pending == 0)
			$display("** sph_pair_viscous_force_unit: PASSED **");
		else
			$display("** sph_pair_viscous_force_unit: FAILED **");
		$finish;
	end

endmodule

// File: files.f
hdl/sphvf_pkg.sv
hdl/sphvf_hmean.sv
hdl/sphvf_qdiv.sv
hdl/sph_pair_viscous_force_unit.sv
tb/sphvf_checker.sv
tb/tb_sph_pair_viscous_force_unit.sv
